@@ hw/rtl/ipihc_pkg.sv @@
// Shared types and constants for the incremental PI heater controller.
// Used by ipihc_ctrl, ipihc_datapath and incremental_pi_heater_control.
// No dependencies.
package ipihc_pkg;

   // Fixed-point scaling of temperatures and drive levels.
   localparam int FRAC_BITS   = 8;
   localparam int DRIVE_W     = 12;
   localparam int ERR_W       = 17;
   localparam int ACC_W       = 36;
   localparam int MUL_W       = 19;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int DUTY_SHIFT  = FRAC_BITS + 2;   // full drive is 3 << DUTY_SHIFT
   localparam int DIV3_SHIFT  = 19;
   localparam int QUOT_W      = 18;

   localparam logic [DRIVE_W-1:0] FULL_DRIVE = DRIVE_W'(12 << FRAC_BITS);
   localparam logic [MUL_W-1:0]   DIV3_RECIP = MUL_W'(((1 << DIV3_SHIFT) + 2) / 3);
   localparam logic [ACC_W-1:0]   ROUND_HALF = ACC_W'(1 << 15);

   // Configuration register map.
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_CUR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PREV = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SP_FLOOR  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SP_CEIL   = 3'd4;

   localparam logic [15:0] GAIN_CUR_RST  = 16'd13894;
   localparam logic [15:0] GAIN_PREV_RST = 16'd13763;
   localparam logic [15:0] PERIOD_RST    = 16'd5000;
   localparam logic [6:0]  SP_FLOOR_RST  = 7'd20;
   localparam logic [6:0]  SP_CEIL_RST   = 7'd60;
   localparam logic [6:0]  SETPOINT_RST  = 7'd35;
   localparam logic [7:0]  ASCII_ZERO    = 8'd48;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_CUR,
      ST_MUL_PREV,
      ST_ACC_PREV,
      ST_COMMIT,
      ST_SP_CHECK,
      ST_MUL_DUTY,
      ST_MUL_DIV3,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MUL_CUR,
      MUL_PREV,
      MUL_DUTY,
      MUL_DIV3
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        commit;
      logic        sp_update;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic is_setpoint;
   } dp_status_type;

endpackage

@@ hw/rtl/ipihc_ctrl.sv @@
// Sequencer for the incremental PI heater controller: steps the shared
// multiplier and accumulator and owns both handshakes. Depends on ipihc_pkg.
module ipihc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output ipihc_pkg::dp_cmd_type   cmd,
   input  ipihc_pkg::dp_status_type status
);
   import ipihc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.mul_sel    = MUL_CUR;
      cmd.acc_op     = ACC_HOLD;
      req_tready     = 1'b0;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL_CUR;
            end
         end
         ST_MUL_CUR: begin
            if (status.is_setpoint) begin
               state_in = ST_SP_CHECK;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = MUL_CUR;
               cmd.acc_op  = ACC_LOAD;
               state_in    = ST_MUL_PREV;
            end
         end
         ST_MUL_PREV: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_PREV;
            cmd.acc_op  = ACC_ADD;
            state_in    = ST_ACC_PREV;
         end
         ST_ACC_PREV: begin
            cmd.acc_op = ACC_SUB;
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_MUL_DUTY;
         end
         ST_SP_CHECK: begin
            cmd.sp_update = 1'b1;
            state_in      = ST_MUL_DUTY;
         end
         ST_MUL_DUTY: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DUTY;
            state_in    = ST_MUL_DIV3;
         end
         ST_MUL_DIV3: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DIV3;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.out_load  = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;

   // A finished result always lands in the output register and frees the sequencer.
   a_finish_to_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && (!rsp_tvalid_ff || rsp_tready))
      |=> (rsp_tvalid_ff && state_ff == ST_IDLE))
      else $error("finished result not presented");

   // An accepted item starts work on the next cycle.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_MUL_CUR))
      else $error("accepted item did not start");

   // The previous error and drive level are only updated by sample items.
   a_commit_sample: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !status.is_setpoint)
      else $error("commit on a set-point item");

   // The output register is never overwritten while a result is stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready) |-> !cmd.out_load)
      else $error("stalled result overwritten");

endmodule

@@ hw/rtl/ipihc_datapath.sv @@
// Datapath of the incremental PI heater controller: configuration registers,
// shared multiplier, accumulator, set-point check and result register. Uses ipihc_pkg.
module ipihc_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [ipihc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ipihc_pkg::CSR_DAT_W-1:0]      csr_wdata,
   input  logic [0:0]                           req_tuser,
   input  logic [ipihc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic [ipihc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  ipihc_pkg::dp_cmd_type                cmd,
   output ipihc_pkg::dp_status_type             status
);
   import ipihc_pkg::*;

   // Configuration registers.
   logic [15:0] gain_cur_ff, gain_prev_ff, period_ff;
   logic [6:0]  sp_floor_ff, sp_ceil_ff;

   // Controller state.
   logic [ERR_W-1:0]   prev_err_ff;
   logic [DRIVE_W-1:0] prev_out_ff;
   logic [6:0]         setpoint_ff;

   // Per-item work registers.
   logic               func_ff;
   logic [ERR_W-1:0]   err_ff, err_in;
   logic [7:0]         tens_ff, ones_ff;
   logic               taken_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [RSP_DATA_W-1:0] out_ff;

   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [ERR_W:0]   err_wide;
   logic [ACC_W-1:0]        acc_round;
   logic signed [ACC_W-17:0] y_val;
   logic [DRIVE_W-1:0]      y_clamp;
   logic [12:0]             tens_v, ones_v, ed_val;
   logic                    sp_ok;
   logic [15:0]             duty_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_cur_ff  <= GAIN_CUR_RST;
         gain_prev_ff <= GAIN_PREV_RST;
         period_ff    <= PERIOD_RST;
         sp_floor_ff  <= SP_FLOOR_RST;
         sp_ceil_ff   <= SP_CEIL_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GAIN_CUR:  gain_cur_ff  <= csr_wdata;
            CSR_GAIN_PREV: gain_prev_ff <= csr_wdata;
            CSR_PERIOD:    period_ff    <= csr_wdata;
            CSR_SP_FLOOR:  sp_floor_ff  <= csr_wdata[6:0];
            CSR_SP_CEIL:   sp_ceil_ff   <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   // Error = set-point scaled to the temperature format minus the sample,
   // saturated to the stored width.
   always_comb begin
      err_wide = $signed({3'b000, setpoint_ff, FRAC_BITS'(0)})
               - $signed({{(ERR_W + 1 - 16){req_tdata[15]}}, req_tdata[15:0]});
      if (err_wide > $signed((ERR_W + 1)'(65535))) begin
         err_in = ERR_W'(65535);
      end else if (err_wide < -$signed((ERR_W + 1)'(65536))) begin
         err_in = ERR_W'(-65536);
      end else begin
         err_in = err_wide[ERR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_tuser[0];
         err_ff  <= err_in;
         tens_ff <= req_tdata[23:16];
         ones_ff <= req_tdata[31:24];
      end
   end

   // Shared multiplier, registered output.
   always_comb begin
      case (cmd.mul_sel)
         MUL_CUR: begin
            mul_a = $signed({3'b000, gain_cur_ff});
            mul_b = $signed({{(MUL_W - ERR_W){err_ff[ERR_W-1]}}, err_ff});
         end
         MUL_PREV: begin
            mul_a = $signed({3'b000, gain_prev_ff});
            mul_b = $signed({{(MUL_W - ERR_W){prev_err_ff[ERR_W-1]}}, prev_err_ff});
         end
         MUL_DUTY: begin
            mul_a = $signed({3'b000, period_ff});
            mul_b = $signed({(MUL_W - DRIVE_W)'(0), prev_out_ff});
         end
         MUL_DIV3: begin
            mul_a = $signed({1'b0, prod_ff[DUTY_SHIFT+QUOT_W-1:DUTY_SHIFT]});
            mul_b = $signed(DIV3_RECIP);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.acc_op)
         ACC_LOAD: acc_ff <= {(ACC_W - DRIVE_W - 16)'(0), prev_out_ff, 16'd0};
         ACC_ADD:  acc_ff <= acc_ff + prod_ff[ACC_W-1:0];
         ACC_SUB:  acc_ff <= acc_ff - prod_ff[ACC_W-1:0];
         default: begin
         end
      endcase
   end

   // Round half up from 16 extra fraction bits, then clamp to 0..full drive.
   always_comb begin
      acc_round = acc_ff + ROUND_HALF;
      y_val     = $signed(acc_round[ACC_W-1:16]);
      if (y_val < 0) begin
         y_clamp = '0;
      end else if (y_val > $signed({(ACC_W - 16 - DRIVE_W)'(0), FULL_DRIVE})) begin
         y_clamp = FULL_DRIVE;
      end else begin
         y_clamp = y_val[DRIVE_W-1:0];
      end
   end

   // Two ASCII digits to a value, taken only strictly inside the limits.
   always_comb begin
      tens_v = {5'b00000, tens_ff} - {5'b00000, ASCII_ZERO};
      ones_v = {5'b00000, ones_ff} - {5'b00000, ASCII_ZERO};
      ed_val = (tens_v << 3) + (tens_v << 1) + ones_v;
      sp_ok  = ($signed(ed_val) > $signed({6'b000000, sp_floor_ff}))
            && ($signed(ed_val) < $signed({6'b000000, sp_ceil_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= '0;
         prev_out_ff <= '0;
         setpoint_ff <= SETPOINT_RST;
      end else begin
         if (cmd.commit) begin
            prev_err_ff <= err_ff;
            prev_out_ff <= y_clamp;
         end
         if (cmd.sp_update && sp_ok) begin
            setpoint_ff <= ed_val[6:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         taken_ff <= 1'b0;
      end else if (cmd.sp_update) begin
         taken_ff <= sp_ok;
      end
   end

   assign duty_val = prod_ff[DIV3_SHIFT+15:DIV3_SHIFT];

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff <= {4'b0000, taken_ff, setpoint_ff, duty_val, prev_out_ff};
      end
   end

   assign rsp_tdata          = out_ff;
   assign status.is_setpoint = func_ff;

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      prev_out_ff <= FULL_DRIVE)
      else $error("drive level above full drive");

   a_sp_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && setpoint_ff != $past(setpoint_ff)) |-> $past(cmd.sp_update))
      else $error("set-point changed outside a set-point check");

   a_err_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && prev_err_ff != $past(prev_err_ff)) |-> $past(cmd.commit))
      else $error("previous error changed outside commit");

endmodule

@@ hw/rtl/incremental_pi_heater_control.sv @@
// One item is in work at a time, so a new transfer is not taken before the last one's
// result sits in the output register; a sample uses the single shared 19x19 multiplier
// four times. The next item is taken as soon as the result sits in the output register.
// Reset (synchronous, active high) restores the default gains, PWM period, limits,
// a set-point of 35 and clears the previous error and output.
module incremental_pi_heater_control (
   input  logic        clock,
   input  logic        reset,
   // Configuration write port.
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // measured_temp[15:0], digit_tens[23:16], digit_ones[31:24]
   input  logic [0:0]  req_tuser,   // func[0]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // drive_level[11:0], duty_count[27:12],
                                    // setpoint_now[34:28], setpoint_taken[35], zero[39:36]
);
   import ipihc_pkg::*;

   // The controller sequences one item at a time through the datapath: a sample
   // runs two multiply-accumulate steps for the PI update, rounds and clamps the
   // new drive level, then scales it to a PWM compare value by multiplying with
   // the period and dividing by full drive through a reciprocal multiply. A
   // set-point request checks the decoded digits against the limits instead, and
   // reuses the same duty scaling on the unchanged drive level.
   dp_cmd_type    cmd;
   dp_status_type status;

   ipihc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // The datapath holds the configuration registers, the loop state and the
   // output register, which lets the result wait while the next item is taken.
   ipihc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

@@ tb/ipihc_tb_pkg.sv @@
`timescale 1ns / 100ps
// Verification types for the incremental PI heater controller bench.
// Holds the request kinds and the layout of one result transfer; no dependencies.
package ipihc_tb_pkg;

   typedef enum logic {
      FUNC_SAMPLE   = 1'b0,
      FUNC_SETPOINT = 1'b1
   } func_type;

   // An index outside the register map; writes to it must change nothing.
   localparam logic [2:0] CSR_NONE = 3'd7;

   // Packed so that the low 36 bits of rsp_tdata map straight onto it.
   typedef struct packed {
      logic        taken;
      logic [6:0]  setpoint;
      logic [15:0] duty;
      logic [11:0] drive;
   } heater_reply_type;

endpackage

@@ tb/ipihc_checker.sv @@
`timescale 1ns / 100ps
// Checker for incremental_pi_heater_control: snoops the register port and both stream
// channels, forecasts every result transfer and compares it field by field.
// Depends on ipihc_pkg and ipihc_tb_pkg.
module ipihc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   output int          mismatches,
   output int          outstanding,
   output int          results_seen,
   output int          samples_seen,
   output int          requests_seen,
   output int          taken_seen,
   output int          limit_seen
);
   import ipihc_pkg::*;
   import ipihc_tb_pkg::*;

   // Shadow copy of the registers and of the regulator state.
   logic [15:0]             gain_cur, gain_prev, period;
   logic [6:0]              sp_floor, sp_ceil, setpoint;
   logic signed [ERR_W-1:0] last_error;
   logic [DRIVE_W-1:0]      last_drive;

   heater_reply_type forecast_q[$];
   int n_bad, n_results, n_samples, n_requests, n_taken, n_limit;

   // One control step or set-point request, updating the shadow state.
   task automatic advance_regulator(input func_type kind, input logic [31:0] word,
                                    output heater_reply_type reply);
      longint temp_v, err_v, acc_v, drive_v;
      int     wanted;
      reply = '0;
      if (kind == FUNC_SAMPLE) begin
         temp_v = longint'($signed(word[15:0]));
         err_v  = (longint'(setpoint) <<< FRAC_BITS) - temp_v;
         if (err_v > 65535)
            err_v = 65535;
         if (err_v < -65536)
            err_v = -65536;
         acc_v = longint'(gain_cur) * err_v - longint'(gain_prev) * longint'(last_error)
               + (longint'(last_drive) <<< 16);
         // Round half up, then keep the drive between off and full.
         drive_v = (acc_v + 32768) >>> 16;
         if (drive_v > longint'(FULL_DRIVE))
            drive_v = longint'(FULL_DRIVE);
         if (drive_v < 0)
            drive_v = 0;
         last_error = err_v[ERR_W-1:0];
         last_drive = drive_v[DRIVE_W-1:0];
      end else begin
         wanted = 10 * (int'(word[23:16]) - int'(ASCII_ZERO))
                + (int'(word[31:24]) - int'(ASCII_ZERO));
         if (wanted > int'(sp_floor) && wanted < int'(sp_ceil)) begin
            setpoint    = wanted[6:0];
            reply.taken = 1'b1;
         end
      end
      reply.drive    = last_drive;
      reply.duty     = 16'((longint'(period) * longint'(last_drive)) / longint'(FULL_DRIVE));
      reply.setpoint = setpoint;
   endtask

   always @(posedge clock) begin
      heater_reply_type want, got;
      if (reset) begin
         gain_cur   = GAIN_CUR_RST;
         gain_prev  = GAIN_PREV_RST;
         period     = PERIOD_RST;
         sp_floor   = SP_FLOOR_RST;
         sp_ceil    = SP_CEIL_RST;
         setpoint   = SETPOINT_RST;
         last_error = '0;
         last_drive = '0;
         forecast_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GAIN_CUR:  gain_cur  = csr_wdata;
               CSR_GAIN_PREV: gain_prev = csr_wdata;
               CSR_PERIOD:    period    = csr_wdata;
               CSR_SP_FLOOR:  sp_floor  = csr_wdata[6:0];
               CSR_SP_CEIL:   sp_ceil   = csr_wdata[6:0];
               default: ;
            endcase
         end
         // Retire before forecasting: a result can never belong to a request
         // accepted at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            got = heater_reply_type'(rsp_tdata[35:0]);
            n_results++;
            if (forecast_q.size() == 0) begin
               n_bad++;
               if (n_bad <= 10)
                  $display("%t: result transfer %h arrived with nothing outstanding",
                           $realtime, rsp_tdata);
            end else begin
               want = forecast_q.pop_front();
               if (got.drive !== want.drive || got.duty !== want.duty ||
                   got.setpoint !== want.setpoint || got.taken !== want.taken ||
                   rsp_tdata[39:36] !== 4'b0000) begin
                  n_bad++;
                  if (n_bad <= 10) begin
                     $display("%t: result mismatch, expected drive %0d duty %0d setpoint %0d taken %0d",
                              $realtime, want.drive, want.duty, want.setpoint, want.taken);
                     $display("   got drive %0d duty %0d setpoint %0d taken %0d pad %h",
                              got.drive, got.duty, got.setpoint, got.taken, rsp_tdata[39:36]);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            advance_regulator(func_type'(req_tuser[0]), req_tdata, want);
            forecast_q.push_back(want);
            if (func_type'(req_tuser[0]) == FUNC_SAMPLE) begin
               n_samples++;
               if (want.drive == '0 || want.drive == FULL_DRIVE)
                  n_limit++;
            end else begin
               n_requests++;
               if (want.taken)
                  n_taken++;
            end
         end
      end
      mismatches    <= n_bad;
      outstanding   <= forecast_q.size();
      results_seen  <= n_results;
      samples_seen  <= n_samples;
      requests_seen <= n_requests;
      taken_seen    <= n_taken;
      limit_seen    <= n_limit;
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the incremental_pi_heater_control bench: clock, reset, register writes and
// both stream sides, with ipihc_checker beside the block doing all prediction.
// Depends on ipihc_pkg, ipihc_tb_pkg, ipihc_checker and the block itself.
module tb_top;
   import ipihc_pkg::*;
   import ipihc_tb_pkg::*;

   localparam int RUN_LIMIT = 400000;   // cycles; the slowest correct run needs far fewer
   localparam int BACKLOG   = 300;      // cycles the receiver holds off once

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = CSR_GAIN_CUR;
   logic [15:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // measured_temp[15:0], digit_tens[23:16], digit_ones[31:24]
   logic [0:0]  req_tuser  = '0;   // func[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // drive_level[11:0], duty_count[27:12],
                                   // setpoint_now[34:28], setpoint_taken[35]

   int mismatches, outstanding, results_seen;
   int samples_seen, requests_seen, taken_seen, limit_seen;
   int cycle_count  = 0;
   int settings_run = 1;           // the reset values count as the first setting
   int walk_temp    = 35 << FRAC_BITS;
   bit steady       = 1'b0;        // when set, neither side idles
   bit backlog_done = 1'b0;

   always #10 clock = ~clock;

   incremental_pi_heater_control dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ipihc_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .results_seen  (results_seen),
      .samples_seen  (samples_seen),
      .requests_seen (requests_seen),
      .taken_seen    (taken_seen),
      .limit_seen    (limit_seen)
   );

   // Watchdog: a hung handshake must still end the run with a verdict.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("Run stopped at the cycle limit with %0d transfers outstanding", outstanding);
         $display("incremental_pi_heater_control test failed");
         $finish;
      end
   end

   // Receiver. It stalls at random, about 28 times in a hundred, except during the steady
   // stretch. Once, after 400 results, it refuses results for a long backlog so that
   // the block fills up and has to push back on the request side while the sender
   // keeps offering transfers.
   initial begin
      forever begin
         @(posedge clock);
         if (!backlog_done && results_seen >= 400) begin
            backlog_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (BACKLOG) @(posedge clock);
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 28);
         end
      end
   end

   // Offers one request transfer and returns at the edge where it was accepted.
   // The optional gap of idle cycles lands on any point of the block's step sequence.
   // When there is no gap, tvalid simply stays high.
   task automatic send_item(input func_type kind, input logic [15:0] temp,
                            input logic [7:0] tens, input logic [7:0] ones);
      if (!steady && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {ones, tens, temp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops offering and waits until every forecast result has come back. The first
   // edge is always waited for, so that the checker has seen the last acceptance.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // A register setting is only changed with the block idle.
   task automatic apply_settings(input logic [15:0] gain_c, input logic [15:0] gain_p,
                                 input logic [15:0] per, input logic [6:0] floor_v,
                                 input logic [6:0] ceil_v);
      settle();
      write_reg(CSR_GAIN_CUR, gain_c);
      write_reg(CSR_GAIN_PREV, gain_p);
      write_reg(CSR_PERIOD, per);
      write_reg(CSR_SP_FLOOR, 16'(floor_v));
      write_reg(CSR_SP_CEIL, 16'(ceil_v));
      csr_we <= 1'b0;
      settings_run++;
   endtask

   // Random traffic. Most samples follow a slow temperature walk so that the
   // regulator spends time away from its clamps; the rest are wide jumps or
   // arbitrary 16-bit words. Most set-point requests carry real digits.
   task automatic run_random(input int count);
      int pick;
      logic [15:0] temp;
      logic [7:0]  tens, ones;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 22) begin
            if ($urandom_range(99) < 70) begin
               tens = ASCII_ZERO + 8'($urandom_range(9));
               ones = ASCII_ZERO + 8'($urandom_range(9));
            end else begin
               tens = 8'($urandom);
               ones = 8'($urandom);
            end
            send_item(FUNC_SETPOINT, 16'($urandom), tens, ones);
         end else begin
            pick = $urandom_range(99);
            if (pick < 10) begin
               temp = 16'($urandom);
            end else if (pick < 35) begin
               temp = 16'(int'($urandom_range(32000)) - 10240);
            end else begin
               if ($urandom_range(99) < 3)
                  walk_temp = int'($urandom_range(15, 70)) << FRAC_BITS;
               walk_temp = walk_temp + int'($urandom_range(800)) - 400;
               if (walk_temp < -10240)
                  walk_temp = -10240;
               if (walk_temp > 21760)
                  walk_temp = 21760;
               temp = 16'(walk_temp);
            end
            send_item(FUNC_SAMPLE, temp, 8'($urandom), 8'($urandom));
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset values: limits of the temperature field
      // first, starting from the reset set-point of 35 degrees.
      send_item(FUNC_SAMPLE, 16'(35 << FRAC_BITS), 8'($urandom), 8'($urandom));
      send_item(FUNC_SAMPLE, 16'(-10240), 8'($urandom), 8'($urandom));
      send_item(FUNC_SAMPLE, 16'(21760), 8'($urandom), 8'($urandom));
      send_item(FUNC_SAMPLE, 16'h8000, 8'($urandom), 8'($urandom));
      send_item(FUNC_SAMPLE, 16'h7FFF, 8'($urandom), 8'($urandom));
      send_item(FUNC_SAMPLE, 16'h0000, 8'($urandom), 8'($urandom));
      // A valid request, then one exactly at the floor and one at the ceiling,
      // neither of which may be taken.
      send_item(FUNC_SETPOINT, 16'($urandom), ASCII_ZERO + 8'd4, ASCII_ZERO + 8'd2);
      send_item(FUNC_SAMPLE, 16'((42 << FRAC_BITS) + 1), 8'($urandom), 8'($urandom));
      send_item(FUNC_SETPOINT, 16'($urandom), ASCII_ZERO + 8'd2, ASCII_ZERO + 8'd0);
      send_item(FUNC_SETPOINT, 16'($urandom), ASCII_ZERO + 8'd6, ASCII_ZERO + 8'd0);
      send_item(FUNC_SETPOINT, 16'($urandom), ASCII_ZERO + 8'd2, ASCII_ZERO + 8'd1);
      send_item(FUNC_SETPOINT, 16'($urandom), ASCII_ZERO + 8'd5, ASCII_ZERO + 8'd9);
      // Bytes that are not digits: the raw formula decides, which can go negative,
      // far too large, or land inside the window by accident.
      send_item(FUNC_SETPOINT, 16'($urandom), 8'h00, 8'h00);
      send_item(FUNC_SETPOINT, 16'($urandom), 8'hFF, 8'hFF);
      send_item(FUNC_SETPOINT, 16'($urandom), ASCII_ZERO + 8'd10, ASCII_ZERO);
      send_item(FUNC_SETPOINT, 16'($urandom), ASCII_ZERO + 8'd1, ASCII_ZERO + 8'd20);
      send_item(FUNC_SETPOINT, 16'($urandom), ASCII_ZERO, ASCII_ZERO + 8'd25);
      // Around the new set-point, then hot enough that the raw output goes
      // negative and has to clamp to zero, twice in a row.
      send_item(FUNC_SAMPLE, 16'((25 << FRAC_BITS) - 512), 8'($urandom), 8'($urandom));
      send_item(FUNC_SAMPLE, 16'(25 << FRAC_BITS), 8'($urandom), 8'($urandom));
      send_item(FUNC_SAMPLE, 16'((25 << FRAC_BITS) + 2560), 8'($urandom), 8'($urandom));
      send_item(FUNC_SAMPLE, 16'(21760), 8'($urandom), 8'($urandom));
      send_item(FUNC_SAMPLE, 16'(21760), 8'($urandom), 8'($urandom));

      run_random(280);   // reset values; the receiver backlog falls in the next run

      // Largest present gain, no memory of the previous error, widest window.
      apply_settings(16'hFFFF, 16'h0000, 16'hFFFF, 7'd0, 7'd99);
      run_random(280);

      // Only the previous error acts; the window is empty, so nothing is taken.
      apply_settings(16'h0000, 16'hFFFF, 16'd1, 7'd99, 7'd0);
      run_random(280);

      // A zero PWM period forces every compare value to zero.
      apply_settings(16'($urandom), 16'($urandom), 16'd0,
                     7'($urandom_range(99)), 7'($urandom_range(99)));
      run_random(280);

      // Random setting, with a long stretch in which neither side idles.
      apply_settings(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)),
                     7'($urandom_range(40)), 7'($urandom_range(50, 99)));
      steady = 1'b1;
      run_random(200);
      steady = 1'b0;
      run_random(80);

      // Back to the power-on values; a write outside the map must be ignored.
      apply_settings(GAIN_CUR_RST, GAIN_PREV_RST, PERIOD_RST, SP_FLOOR_RST, SP_CEIL_RST);
      write_reg(CSR_NONE, 16'($urandom));
      csr_we <= 1'b0;
      run_random(280);

      settle();
      repeat (16) @(posedge clock);

      $display("Ran %0d control steps (%0d at a drive limit) and %0d set-point requests",
               samples_seen, limit_seen, requests_seen);
      $display("(%0d taken) over %0d register settings; %0d results checked, %0d mismatches",
               taken_seen, settings_run, results_seen, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("incremental_pi_heater_control test passed");
      end else begin
         $display("incremental_pi_heater_control test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/ipihc_pkg.sv
hw/rtl/ipihc_ctrl.sv
hw/rtl/ipihc_datapath.sv
hw/rtl/incremental_pi_heater_control.sv
tb/ipihc_tb_pkg.sv
tb/ipihc_checker.sv
tb/tb_top.sv
